FILE: rtl/bba_pkg.sv
package bba_pkg;

    // Built capacity of the occupancy map
    localparam int MAX_BLOCKS_DEF = 64;

    // Configuration register indexes
    localparam logic [1:0] CFG_POOL_BASE     = 2'd0;
    localparam logic [1:0] CFG_BLOCK_SIZE    = 2'd1;
    localparam logic [1:0] CFG_BLOCKS_IN_USE = 2'd2;

    // Reset values of the configuration registers
    localparam logic [31:0] POOL_BASE_RST     = 32'd0;
    localparam logic [15:0] BLOCK_SIZE_RST    = 16'd8;
    localparam logic [6:0]  BLOCKS_IN_USE_RST = 7'd64;

    // Operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Request and response payloads
    typedef struct packed {
        logic        operation;
        logic [31:0] free_address;
    } t_req;

    typedef struct packed {
        logic        ok;
        logic [31:0] block_address;
    } t_rsp;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;    // capture request, restart walk at block 0
        logic step;    // advance to the next block
        logic finish;  // update map, write response register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic hit;       // current block satisfies the request
        logic at_end;    // walk has passed the last managed block
        logic null_free; // free of address zero
        logic out_free;  // response register can take a result this cycle
    } t_status;

endpackage

FILE: rtl/bba_ctrl.sv
module bba_ctrl
    import bba_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_done;

    // Walk ends on a match, past the last block, or on a null free
    assign w_done = i_status.hit | i_status.at_end | i_status.null_free;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_done && i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_SCAN: begin
                // a finished walk holds while the response register is full
                o_cmd.finish = w_done & i_status.out_free;
                o_cmd.step   = ~w_done;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/bba_datapath.sv
module bba_datapath
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  t_req        i_req,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_rsp        o_out_data
);

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;
    localparam logic [CMP_W-1:0] MAX_CNT = CMP_W'(MAX_BLOCKS);

    logic [31:0]           r_pool_base;
    logic [15:0]           r_block_size;
    logic [6:0]            r_blocks_in_use;
    logic [MAX_BLOCKS-1:0] r_map;
    t_req                  r_req;
    logic [CNT_W-1:0]      r_idx;
    logic [31:0]           r_addr;
    logic                  r_out_valid;
    t_rsp                  r_out;

    logic [CMP_W-1:0] w_count;
    logic             w_at_end;
    logic             w_used;
    logic             w_hit;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base     <= POOL_BASE_RST;
            r_block_size    <= BLOCK_SIZE_RST;
            r_blocks_in_use <= BLOCKS_IN_USE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_POOL_BASE:     r_pool_base     <= i_cfg_data;
                CFG_BLOCK_SIZE:    r_block_size    <= i_cfg_data[15:0];
                CFG_BLOCKS_IN_USE: r_blocks_in_use <= i_cfg_data[6:0];
                default:           r_pool_base     <= r_pool_base;
            endcase
        end
    end

    // Managed count, saturated to the built capacity
    assign w_count = (CMP_W'(r_blocks_in_use) > MAX_CNT) ? MAX_CNT
                                                          : CMP_W'(r_blocks_in_use);

    // Current block status
    assign w_at_end = (CMP_W'(r_idx) >= w_count);
    assign w_used   = r_map[r_idx[IDX_W-1:0]];
    assign w_hit    = ~w_at_end & ((r_req.operation == OP_ALLOC) ? ~w_used
                                                                 : (r_addr == r_req.free_address));

    assign o_status.hit       = w_hit;
    assign o_status.at_end    = w_at_end;
    assign o_status.null_free = (r_req.operation == OP_FREE) && (r_req.free_address == 32'd0);
    assign o_status.out_free  = ~r_out_valid | i_out_ready;

    // Request capture and walk: index and running start address
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= i_req;
            r_idx  <= '0;
            r_addr <= r_pool_base;
        end else if (i_cmd.step) begin
            r_idx  <= r_idx + CNT_W'(1);
            r_addr <= r_addr + 32'(r_block_size);
        end
    end

    // Occupancy map
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map <= '0;
        end else if (i_cmd.finish && w_hit && !o_status.null_free) begin
            r_map[r_idx[IDX_W-1:0]] <= (r_req.operation == OP_ALLOC);
        end
    end

    // Response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out.ok            <= w_hit & ~o_status.null_free;
            r_out.block_address <= (w_hit && r_req.operation == OP_ALLOC) ? r_addr : 32'd0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/bitmap_block_allocator.sv
// Channel   | Signals                                        | Direction
// ----------+------------------------------------------------+-----------
// request   | i_in_valid, o_in_ready, i_in_data (t_req)      | in
// response  | o_out_valid, i_out_ready, o_out_data (t_rsp)   | out
// config    | i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data | in
//
// One request at a time. The accept cycle is followed by a walk over the
// blocks, one block per cycle, ending on the first matching block, past
// the last managed block if none matches; a null free takes no step.
// Reset (i_rst_n low, synchronous) marks every block free and loads the
// register defaults. A full response register stalls the end of the walk;
// the next request is taken as soon as the result is written.
module bitmap_block_allocator
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_req        i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_rsp        o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;

    // Configuration is always taken
    assign o_cfg_ready = 1'b1;

    bba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    bba_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (i_in_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
